// File: design/brtc_pkg.sv
// ----------------------------------------------------------------------------
// BCD RTC register bank package
// Shared types, constants and BCD helpers for the clock/calendar bank.
// ----------------------------------------------------------------------------
package brtc_pkg;

  // Bank geometry (BANK_SIZE must stay a power of two)
  localparam int BANK_SIZE = 64;
  localparam int ADDR_W    = $clog2(BANK_SIZE);
  localparam int NUM_TREGS = 7;
  localparam int TREG_AW   = $clog2(NUM_TREGS);

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET_PTR = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  // Time register indexes
  localparam logic [TREG_AW-1:0] TR_SEC   = 3'd0;
  localparam logic [TREG_AW-1:0] TR_MIN   = 3'd1;
  localparam logic [TREG_AW-1:0] TR_HOUR  = 3'd2;
  localparam logic [TREG_AW-1:0] TR_WDAY  = 3'd3;
  localparam logic [TREG_AW-1:0] TR_DATE  = 3'd4;
  localparam logic [TREG_AW-1:0] TR_MONTH = 3'd5;
  localparam logic [TREG_AW-1:0] TR_YEAR  = 3'd6;

  localparam logic [7:0] HALT_BIT    = 8'h80;
  localparam logic [7:0] MODE12_BIT  = 8'h40;
  localparam logic [7:0] PM_BIT      = 8'h20;
  localparam logic [7:0] MASK_HOUR12 = 8'h1F;
  localparam logic [7:0] MASK_HOUR24 = 8'h3F;
  localparam logic [7:0] MASK_SECMIN = 8'h7F;
  localparam logic [7:0] MASK_WDAY   = 8'h07;
  localparam logic [7:0] MASK_DATE   = 8'h3F;
  localparam logic [7:0] MASK_MONTH  = 8'h1F;
  localparam logic [7:0] LAST_YEAR_OFS = 8'd99;

  localparam logic [5:0] MONTH_LEN [12] = '{
    6'd31, 6'd28, 6'd31, 6'd30, 6'd31, 6'd30,
    6'd31, 6'd31, 6'd30, 6'd31, 6'd30, 6'd31
  };

  // Reset contents of the time registers (BCD)
  localparam logic [7:0] TREG_RST [NUM_TREGS] = '{
    8'h00, 8'h00, 8'h14, 8'h03, 8'h13, 8'h05, 8'h26
  };

  typedef struct packed {
    logic               tick;
    logic               wr;
    logic [TREG_AW-1:0] addr;
    logic [7:0]         data;
  } time_cmd_t;

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
  endfunction

  // Divide by ten through a reciprocal multiply; exact for 8-bit values
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = 16'(v) * 16'd205;
    q    = 8'(prod >> 11);
    r    = v - 8'(q * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [5:0] month_days(input logic [4:0] m, input logic [7:0] yofs);
    logic leap;
    // Years 2000..2255: only 2100 and 2200 are century non-leap years
    leap = (yofs[1:0] == 2'b00) && (yofs != 8'd100) && (yofs != 8'd200);
    if (m == 5'd2 && leap) begin
      return 6'd29;
    end else if (m >= 5'd1 && m <= 5'd12) begin
      return MONTH_LEN[4'(m - 5'd1)];
    end else begin
      return 6'd30;
    end
  endfunction

endpackage

// File: design/brtc_if.sv
// ----------------------------------------------------------------------------
// BCD RTC channel interfaces
// Valid/ready request and response channels of the register bank.
// ----------------------------------------------------------------------------
interface brtc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data;

  modport source (output valid, output req_type, output data, input ready);
  modport sink   (input valid, input req_type, input data, output ready);
endinterface

interface brtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

// File: design/bcd_rtc_calendar_regs.sv
// ----------------------------------------------------------------------------
// BCD real-time clock and calendar register bank
// Pointer-addressed byte bank with a ticking BCD time/date block.
// ----------------------------------------------------------------------------
//  channel | dir | fields              | notes
//  --------+-----+---------------------+----------------------------------
//  req     | in  | req_type, data      | tick, set pointer, write, read
//  rsp     | out | read_data           | one beat per read request only
//
//  A read passes through the registered read port of the storage RAM into
//  the output register, and the request channel holds off while the read
//  is in flight. A read result waits in the output register; further
//  requests, one more read among them, are still taken while it waits.
//  Reset is synchronous and restores the default time; storage entries
//  read as zero until written.
module bcd_rtc_calendar_regs import brtc_pkg::*; (
  input logic         clk,
  input logic         rst,
  brtc_req_if.sink    req,
  brtc_rsp_if.source  rsp
);

  logic [ADDR_W-1:0]    ptr;
  logic                 pend;
  logic [ADDR_W-1:0]    pend_addr;
  logic                 pend_hit;
  logic                 rsp_valid;
  logic [7:0]           rsp_data;
  logic [BANK_SIZE-1:0] bank_valid;

  logic       fire;
  logic       is_treg;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  logic [7:0] treg_byte;
  logic [7:0] pend_data;
  logic       move;
  req_e       rtype;
  time_cmd_t  cmd;

  assign rtype     = req_e'(req.req_type);
  assign req.ready = !pend;
  assign fire      = req.valid && req.ready;
  assign is_treg   = ptr < ADDR_W'(NUM_TREGS);
  assign ram_we    = fire && rtype == REQ_WRITE && !is_treg;
  assign ram_re    = fire && rtype == REQ_READ;

  assign cmd.tick = fire && rtype == REQ_TICK;
  assign cmd.wr   = fire && rtype == REQ_WRITE && is_treg;
  assign cmd.addr = ptr[TREG_AW-1:0];
  assign cmd.data = req.data;

  brtc_ram #(
    .DEPTH (BANK_SIZE),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (req.data),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  brtc_time u_time (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (pend_addr[TREG_AW-1:0]),
    .rd_byte (treg_byte)
  );

  always_comb begin
    if (pend_addr < ADDR_W'(NUM_TREGS)) begin
      pend_data = treg_byte;
    end else if (pend_hit) begin
      pend_data = ram_rdata;
    end else begin
      pend_data = 8'h00;
    end
  end

  // Hand the read beat on once the output register is free or draining
  assign move = pend && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
      bank_valid <= '0;
    end else begin
      if (fire) begin
        case (rtype)
          REQ_SET_PTR: ptr <= req.data[ADDR_W-1:0];
          REQ_WRITE,
          REQ_READ:    ptr <= ptr + ADDR_W'(1);
          default:     ptr <= ptr;
        endcase
      end
      if (ram_we) begin
        bank_valid[ptr] <= 1'b1;
      end
      if (ram_re) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_addr <= ptr;
      pend_hit  <= bank_valid[ptr];
    end
    if (move) begin
      rsp_data <= pend_data;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;

  a_read_pends: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> pend)
    else $error("read request did not enter the read stage");

  a_read_delivered: assert property (@(posedge clk) disable iff (rst)
    move |=> rsp.valid && rsp.read_data == $past(pend_data))
    else $error("read beat not delivered to the output register");

  a_ptr_set: assert property (@(posedge clk) disable iff (rst)
    fire && rtype == REQ_SET_PTR |=> ptr == $past(req.data[ADDR_W-1:0]))
    else $error("pointer not loaded from a set-pointer request");

  a_store_marked: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> bank_valid[$past(ptr)])
    else $error("stored entry not marked valid");

endmodule

// File: design/brtc_ram.sv
// ----------------------------------------------------------------------------
// BCD RTC storage RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brtc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/brtc_time.sv
// ----------------------------------------------------------------------------
// BCD RTC time keeper
// Time registers, binary counts, one-second advance and BCD encode/decode.
// ----------------------------------------------------------------------------
module brtc_time import brtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  time_cmd_t          cmd,
  input  logic [TREG_AW-1:0] rd_addr,
  output logic [7:0]         rd_byte
);

  logic [7:0] tregs [NUM_TREGS];
  logic [6:0] sec_count;
  logic [6:0] min_count;
  logic [5:0] hour_count;
  logic [2:0] weekday_count;
  logic [5:0] date_count;
  logic [4:0] month_count;
  logic [7:0] year_offset;
  logic       twelve_hour_mode;

  // Decode path
  logic [7:0] wr_bytes [NUM_TREGS];
  logic [6:0] dec_sec;
  logic [6:0] dec_min;
  logic [5:0] dec_hour;
  logic [2:0] dec_wday;
  logic [5:0] dec_date;
  logic [4:0] dec_month;
  logic [7:0] dec_year;
  logic       dec_mode12;

  // Advance path
  logic [6:0] adv_sec;
  logic [6:0] adv_min;
  logic [5:0] adv_hour;
  logic [2:0] adv_wday;
  logic [5:0] adv_date;
  logic [4:0] adv_month;
  logic [7:0] adv_year;
  logic [7:0] enc_bytes [NUM_TREGS];

  logic halted;

  assign halted  = (tregs[TR_SEC] & HALT_BIT) != 8'h00;
  assign rd_byte = (rd_addr < TREG_AW'(NUM_TREGS)) ? tregs[rd_addr] : 8'h00;

  always_comb begin
    logic [7:0] h;
    for (int i = 0; i < NUM_TREGS; i++) begin
      wr_bytes[i] = tregs[i];
    end
    if (cmd.wr && cmd.addr < TREG_AW'(NUM_TREGS)) begin
      wr_bytes[cmd.addr] = cmd.data;
    end
    dec_sec = 7'(from_bcd(wr_bytes[TR_SEC] & MASK_SECMIN));
    dec_min = 7'(from_bcd(wr_bytes[TR_MIN] & MASK_SECMIN));
    dec_mode12 = (wr_bytes[TR_HOUR] & MODE12_BIT) != 8'h00;
    if (dec_mode12) begin
      h = from_bcd(wr_bytes[TR_HOUR] & MASK_HOUR12);
      // 12 AM is midnight, PM shifts by twelve
      if (h == 8'd12) begin
        h = 8'd0;
      end
      if ((wr_bytes[TR_HOUR] & PM_BIT) != 8'h00) begin
        h = h + 8'd12;
      end
    end else begin
      h = from_bcd(wr_bytes[TR_HOUR] & MASK_HOUR24);
    end
    dec_hour  = 6'(h);
    dec_wday  = 3'(from_bcd(wr_bytes[TR_WDAY] & MASK_WDAY));
    dec_date  = 6'(from_bcd(wr_bytes[TR_DATE] & MASK_DATE));
    dec_month = 5'(from_bcd(wr_bytes[TR_MONTH] & MASK_MONTH));
    dec_year  = from_bcd(wr_bytes[TR_YEAR]);
  end

  always_comb begin
    logic [7:0] s_inc;
    logic [7:0] m_inc;
    logic [6:0] h_inc;
    logic [3:0] w_inc;
    logic [6:0] d_inc;
    logic [5:0] mo_inc;
    logic [8:0] y_inc;
    adv_sec   = sec_count;
    adv_min   = min_count;
    adv_hour  = hour_count;
    adv_wday  = weekday_count;
    adv_date  = date_count;
    adv_month = month_count;
    adv_year  = year_offset;
    s_inc  = 8'(sec_count) + 8'd1;
    m_inc  = 8'(min_count) + 8'd1;
    h_inc  = 7'(hour_count) + 7'd1;
    w_inc  = 4'(weekday_count) + 4'd1;
    d_inc  = 7'(date_count) + 7'd1;
    mo_inc = 6'(month_count) + 6'd1;
    y_inc  = 9'(year_offset) + 9'd1;
    // Each field carries only when the one below it wraps
    if (s_inc > 8'd59) begin
      adv_sec = 7'd0;
      if (m_inc > 8'd59) begin
        adv_min = 7'd0;
        if (h_inc > 7'd23) begin
          adv_hour = 6'd0;
          adv_wday = (w_inc > 4'd7) ? 3'd1 : w_inc[2:0];
          if (d_inc > 7'(month_days(month_count, year_offset))) begin
            adv_date = 6'd1;
            if (mo_inc > 6'd12) begin
              adv_month = 5'd1;
              adv_year  = (y_inc > 9'(LAST_YEAR_OFS)) ? 8'd0 : y_inc[7:0];
            end else begin
              adv_month = mo_inc[4:0];
            end
          end else begin
            adv_date = d_inc[5:0];
          end
        end else begin
          adv_hour = h_inc[5:0];
        end
      end else begin
        adv_min = m_inc[6:0];
      end
    end else begin
      adv_sec = s_inc[6:0];
    end
  end

  always_comb begin
    logic [5:0] h;
    logic [7:0] pm;
    enc_bytes[TR_SEC] = to_bcd(8'(adv_sec)) | (tregs[TR_SEC] & HALT_BIT);
    enc_bytes[TR_MIN] = to_bcd(8'(adv_min));
    if (twelve_hour_mode) begin
      h  = adv_hour;
      pm = (h >= 6'd12) ? PM_BIT : 8'h00;
      if (h > 6'd12) begin
        h = h - 6'd12;
      end
      if (h == 6'd0) begin
        h = 6'd12;
      end
      enc_bytes[TR_HOUR] = to_bcd(8'(h)) | MODE12_BIT | pm;
    end else begin
      h  = adv_hour;
      pm = 8'h00;
      enc_bytes[TR_HOUR] = to_bcd(8'(h)) | pm;
    end
    enc_bytes[TR_WDAY]  = to_bcd(8'(adv_wday));
    enc_bytes[TR_DATE]  = to_bcd(8'(adv_date));
    enc_bytes[TR_MONTH] = to_bcd(8'(adv_month));
    enc_bytes[TR_YEAR]  = to_bcd(adv_year);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TREGS; i++) begin
        tregs[i] <= TREG_RST[i];
      end
      sec_count        <= 7'd0;
      min_count        <= 7'd0;
      hour_count       <= 6'd14;
      weekday_count    <= 3'd3;
      date_count       <= 6'd13;
      month_count      <= 5'd5;
      year_offset      <= 8'd26;
      twelve_hour_mode <= 1'b0;
    end else if (cmd.wr) begin
      for (int i = 0; i < NUM_TREGS; i++) begin
        tregs[i] <= wr_bytes[i];
      end
      sec_count        <= dec_sec;
      min_count        <= dec_min;
      hour_count       <= dec_hour;
      weekday_count    <= dec_wday;
      date_count       <= dec_date;
      month_count      <= dec_month;
      year_offset      <= dec_year;
      twelve_hour_mode <= dec_mode12;
    end else if (cmd.tick && !halted) begin
      for (int i = 0; i < NUM_TREGS; i++) begin
        tregs[i] <= enc_bytes[i];
      end
      sec_count     <= adv_sec;
      min_count     <= adv_min;
      hour_count    <= adv_hour;
      weekday_count <= adv_wday;
      date_count    <= adv_date;
      month_count   <= adv_month;
      year_offset   <= adv_year;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BCD RTC register bank testbench
// Drives ticks, pointer sets, writes and reads with random gaps on both
// channels. A scoreboard keeps its own copy of the bank and time counters,
// predicts every read beat and compares it in order.
// ----------------------------------------------------------------------------
module testbench;
  import brtc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 1050;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  class rtc_scoreboard;
    logic [7:0]        bank [BANK_SIZE];
    logic [ADDR_W-1:0] ptr;
    int unsigned       sec, mins, hrs, wday, day, month, year_ofs;
    bit                hour12;
    logic [7:0]        pending_reads [$];
    int                errors, reads_checked, ticks, ptr_sets, writes;

    function new();
      foreach (bank[i]) bank[i] = 8'h00;
      ptr      = '0;
      sec      = 0;
      mins     = 0;
      hrs      = 14;
      wday     = 3;
      day      = 13;
      month    = 5;
      year_ofs = 26;
      hour12   = 1'b0;
      refresh_regs();
    endfunction

    static function logic [7:0] bcd_of(int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    static function int unsigned bin_of(logic [7:0] v);
      return v[7:4] * 10 + v[3:0];
    endfunction

    static function int unsigned days_in_month(int unsigned m, int unsigned y);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (m == 2 && leap) return 29;
      case (m)
        2:                     return 28;
        4, 6, 9, 11:           return 30;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default:               return 30;
      endcase
    endfunction

    function void refresh_regs();
      logic [7:0]  halt;
      int unsigned h;
      halt          = bank[TR_SEC] & HALT_BIT;
      bank[TR_SEC]  = bcd_of(sec) | halt;
      bank[TR_MIN]  = bcd_of(mins);
      if (hour12) begin
        h = hrs;
        bank[TR_HOUR] = (h >= 12) ? PM_BIT : 8'h00;
        if (h > 12) h = h - 12;
        if (h == 0) h = 12;
        bank[TR_HOUR] = bank[TR_HOUR] | bcd_of(h) | MODE12_BIT;
      end else begin
        bank[TR_HOUR] = bcd_of(hrs);
      end
      bank[TR_WDAY]  = bcd_of(wday);
      bank[TR_DATE]  = bcd_of(day);
      bank[TR_MONTH] = bcd_of(month);
      bank[TR_YEAR]  = bcd_of(year_ofs);
    endfunction

    function void reload_counts();
      int unsigned h;
      sec  = bin_of(bank[TR_SEC] & MASK_SECMIN);
      mins = bin_of(bank[TR_MIN] & MASK_SECMIN);
      if ((bank[TR_HOUR] & MODE12_BIT) != 0) begin
        h      = bin_of(bank[TR_HOUR] & MASK_HOUR12);
        hour12 = 1'b1;
        // 12 AM is midnight, PM adds twelve
        if (h == 12) h = 0;
        if ((bank[TR_HOUR] & PM_BIT) != 0) h = h + 12;
        hrs = h;
      end else begin
        hour12 = 1'b0;
        hrs    = bin_of(bank[TR_HOUR] & MASK_HOUR24);
      end
      wday     = bin_of(bank[TR_WDAY] & MASK_WDAY);
      day      = bin_of(bank[TR_DATE] & MASK_DATE);
      month    = bin_of(bank[TR_MONTH] & MASK_MONTH);
      year_ofs = bin_of(bank[TR_YEAR]);
    endfunction

    // Compare after increment so out-of-range counts wrap at once
    function void step_clock();
      sec++;
      if (sec <= 59) return;
      sec = 0;
      mins++;
      if (mins <= 59) return;
      mins = 0;
      hrs++;
      if (hrs <= 23) return;
      hrs = 0;
      wday++;
      if (wday > 7) wday = 1;
      day++;
      if (day <= days_in_month(month, 2000 + year_ofs)) return;
      day = 1;
      month++;
      if (month <= 12) return;
      month = 1;
      year_ofs++;
      if (2000 + year_ofs > 2099) year_ofs = 0;
    endfunction

    function void note_request(req_e kind, logic [7:0] value);
      case (kind)
        REQ_TICK: begin
          ticks++;
          if ((bank[TR_SEC] & HALT_BIT) == 0) begin
            step_clock();
            refresh_regs();
          end
        end
        REQ_SET_PTR: begin
          ptr_sets++;
          ptr = value[ADDR_W-1:0];
        end
        REQ_WRITE: begin
          writes++;
          bank[ptr] = value;
          if (ptr < NUM_TREGS) reload_counts();
          ptr++;
        end
        REQ_READ: begin
          pending_reads.push_back(bank[ptr]);
          ptr++;
        end
      endcase
    endfunction

    function void check_read(logic [7:0] got);
      logic [7:0] want;
      if (pending_reads.size() == 0) begin
        $display("%0t: read beat with none expected, expected none, got %02h", $time, got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got !== want) begin
        $display("%0t: read_data mismatch, expected %02h, got %02h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   clock_sequences = 0;
  int   long_holds = 0;
  bit   sender_calm = 1'b0;
  bit   receiver_calm = 1'b0;
  bit   long_hold_req = 1'b0;

  rtc_scoreboard sb;

  brtc_req_if req_ch();
  brtc_rsp_if rsp_ch();

  bcd_rtc_calendar_regs uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_e'(req_ch.req_type), req_ch.data);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_read(rsp_ch.read_data);
      end
    end
  end

  // Keep valid high across back-to-back beats; drop it only for a gap
  task automatic send_item(req_e kind, logic [7:0] value);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.data     <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int unsigned stall;
    int          beats;
    beats = 0;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = receiver_calm ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      beats++;
      if (beats % 16 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic run_directed();
    int i;
    // reset contents
    for (i = 0; i < NUM_TREGS; i++) send_item(REQ_READ, 8'h00);
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_SET_PTR, 8'h40);
    send_item(REQ_READ, 8'hFF);
    // top of the bank, then wrap back to the seconds register
    send_item(REQ_SET_PTR, 8'hFF);
    send_item(REQ_WRITE, 8'hFF);
    send_item(REQ_READ, 8'h00);
    // halted clock ignores the tick
    send_item(REQ_SET_PTR, 8'h00);
    send_item(REQ_WRITE, HALT_BIT);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_SET_PTR, 8'h00);
    send_item(REQ_READ, 8'h00);
    // 12 AM in twelve-hour mode, then a minute carry
    send_item(REQ_SET_PTR, 8'h02);
    send_item(REQ_WRITE, MODE12_BIT | 8'h12);
    send_item(REQ_SET_PTR, 8'h00);
    send_item(REQ_WRITE, 8'h59);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_SET_PTR, 8'h02);
    send_item(REQ_READ, 8'h00);
  endtask

  // Load a time near a rollover, tick a few times, read the time back
  task automatic run_clock_sequence();
    logic [7:0]  tregs [NUM_TREGS];
    int unsigned yr, mon, dy, secs, hr;
    int          i;
    clock_sequences++;
    case ($urandom_range(0, 5))
      0:       yr = 99;
      1:       yr = 0;
      2:       yr = 4 * $urandom_range(0, 24);
      default: yr = $urandom_range(0, 99);
    endcase
    case ($urandom_range(0, 5))
      0:       mon = 12;
      1:       mon = 2;
      2:       mon = $urandom_range(0, 19);
      default: mon = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 3))
      0, 1:    dy = rtc_scoreboard::days_in_month(mon, 2000 + yr);
      2:       dy = rtc_scoreboard::days_in_month(mon, 2000 + yr) - 1;
      default: dy = $urandom_range(0, 31);
    endcase
    secs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59 - $urandom_range(0, 1);
    tregs[TR_SEC] = rtc_scoreboard::bcd_of(secs) |
                    (($urandom_range(0, 9) == 0) ? HALT_BIT : 8'h00);
    tregs[TR_MIN] = rtc_scoreboard::bcd_of(($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, 59) : 59);
    if ($urandom_range(0, 2) == 0) begin
      hr = ($urandom_range(0, 1) == 0) ? 11 + $urandom_range(0, 1) : $urandom_range(1, 12);
      tregs[TR_HOUR] = MODE12_BIT | rtc_scoreboard::bcd_of(hr) |
                       (($urandom_range(0, 1) == 0) ? PM_BIT : 8'h00);
    end else begin
      hr = ($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23);
      tregs[TR_HOUR] = rtc_scoreboard::bcd_of(hr);
    end
    tregs[TR_WDAY]  = rtc_scoreboard::bcd_of($urandom_range(0, 7));
    tregs[TR_DATE]  = rtc_scoreboard::bcd_of(dy);
    tregs[TR_MONTH] = rtc_scoreboard::bcd_of(mon);
    tregs[TR_YEAR]  = rtc_scoreboard::bcd_of(yr);
    // now and then a raw random byte that need not be valid BCD
    if ($urandom_range(0, 7) == 0) tregs[$urandom_range(0, NUM_TREGS - 1)] = 8'($urandom);
    send_item(REQ_SET_PTR, 8'($urandom_range(0, 3) * BANK_SIZE));
    for (i = 0; i < NUM_TREGS; i++) send_item(REQ_WRITE, tregs[i]);
    repeat ($urandom_range(1, 3)) send_item(REQ_TICK, 8'($urandom));
    send_item(REQ_SET_PTR, 8'($urandom_range(0, 3) * BANK_SIZE));
    repeat ($urandom_range(NUM_TREGS, NUM_TREGS + 2)) send_item(REQ_READ, 8'($urandom));
  endtask

  task automatic run_storage_burst();
    logic [7:0] base;
    int         n;
    base = 8'($urandom);
    n    = $urandom_range(1, 4);
    send_item(REQ_SET_PTR, base);
    repeat (n) send_item(REQ_WRITE, 8'($urandom));
    send_item(REQ_SET_PTR, base);
    repeat (n) send_item(REQ_READ, 8'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 12)) begin
      send_item(req_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  initial begin
    int groups;
    int pick;
    groups = 0;
    sb = new();
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_TICK;
    req_ch.data     <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (items_sent < TARGET_ITEMS) begin
      groups++;
      if (groups == 12 || groups == 45) long_hold_req = 1'b1;
      sender_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        run_clock_sequence();
      end else if (pick < 8) begin
        run_noise();
      end else begin
        run_storage_burst();
      end
    end
    req_ch.valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests: %0d ticks, %0d pointer sets, %0d writes, %0d reads",
             items_sent, sb.ticks, sb.ptr_sets, sb.writes, sb.reads_checked);
    $display("including %0d time-load sequences and %0d long response hold-offs",
             clock_sequences, long_holds);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
